[sv/rbtp_pkg.sv]
// Package: shared constants, opcodes and types of the radial brush texel painter.
`default_nettype none
package rbtp_pkg;

  localparam int DEF_MAX_WIDTH  = 128;
  localparam int DEF_MAX_HEIGHT = 128;
  localparam int DEF_MAX_RADIUS = 32;

  localparam int CH_W    = 16;
  localparam int FRAC    = CH_W - 1;
  localparam int TEXEL_W = 4 * CH_W;
  localparam logic [CH_W-1:0] ONE = CH_W'(1) << FRAC;

  localparam int POS_W   = 7;
  localparam int RAD_W   = 6;
  localparam int OFS_W   = RAD_W + 2;
  localparam int D2_W    = 2 * RAD_W + 1;
  localparam int ROOT_W  = (D2_W + 2 * FRAC + 1) / 2;
  localparam int NUM_W   = RAD_W + FRAC;
  localparam int MUL_W   = ROOT_W + 1;
  localparam int DELTA_W = 20;

  localparam logic [1:0] OP_STAMP = 2'd0;
  localparam logic [1:0] OP_WRITE = 2'd1;
  localparam logic [1:0] OP_FILL  = 2'd2;
  localparam logic [1:0] OP_READ  = 2'd3;

  localparam logic [1:0] CH_NONE = 2'd3;

  typedef struct packed {
    logic signed [OFS_W-1:0] dx;
    logic signed [OFS_W-1:0] dz;
    logic [RAD_W-1:0]        rad;
    logic signed [CH_W-1:0]  gain;
  } calc_req_t;

  function automatic logic [CH_W-1:0] sat_one(input logic [CH_W-1:0] v);
    return (v > ONE) ? ONE : v;
  endfunction

endpackage
`default_nettype wire

[sv/rbtp_ram.sv]
// Generic single-write, single-read RAM with registered read data.
`default_nettype none
module rbtp_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 16384,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic             re,
  input  wire logic [AW-1:0]    raddr,
  output logic      [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule
`default_nettype wire

[sv/rbtp_calc.sv]
// Shared multiply/root/divide unit: falloff delta of one texel, one phase at a time.
`default_nettype none
module rbtp_calc
  import rbtp_pkg::*;
(
  input  wire logic                      clk,
  input  wire logic                      rst,
  input  wire logic                      go,
  input  wire calc_req_t                 req,
  output logic                           done,
  output logic signed [DELTA_W-1:0]      delta
);

  localparam logic [2:0] P_IDLE = 3'd0;
  localparam logic [2:0] P_DX   = 3'd1;
  localparam logic [2:0] P_DZ   = 3'd2;
  localparam logic [2:0] P_SQRT = 3'd3;
  localparam logic [2:0] P_DIV  = 3'd4;
  localparam logic [2:0] P_MUL  = 3'd5;
  localparam logic [2:0] P_OUT  = 3'd6;

  logic [2:0]                  phase;
  logic [4:0]                  step;
  calc_req_t                   rq;
  logic [D2_W-1:0]             d2_acc;
  logic [D2_W+2*FRAC-1:0]      target;
  logic [ROOT_W-1:0]           root;
  logic [NUM_W-1:0]            num;
  logic [RAD_W:0]              rem;
  logic [CH_W-1:0]             quo;
  logic signed [31:0]          prod;

  logic [ROOT_W-1:0]           trial;
  logic signed [MUL_W-1:0]     op_a;
  logic signed [MUL_W-1:0]     op_b;
  logic signed [2*MUL_W-1:0]   mul;
  logic                        sq_le;
  logic signed [NUM_W+1:0]     n_val;
  logic [RAD_W:0]              rem_sh;
  logic                        ge;
  logic signed [31:0]          rnd;

  assign trial = root | (ROOT_W'(1) << step);

  always_comb begin
    unique case (phase)
      P_DX: begin
        op_a = MUL_W'(rq.dx);
        op_b = MUL_W'(rq.dx);
      end
      P_DZ: begin
        op_a = MUL_W'(rq.dz);
        op_b = MUL_W'(rq.dz);
      end
      P_MUL: begin
        op_a = $signed(MUL_W'(quo));
        op_b = MUL_W'(rq.gain);
      end
      default: begin
        op_a = $signed({1'b0, trial});
        op_b = $signed({1'b0, trial});
      end
    endcase
  end

  assign mul    = op_a * op_b;
  assign sq_le  = mul[D2_W+2*FRAC:0] <= {1'b0, target};
  assign n_val  = $signed({2'b00, rq.rad, FRAC'(0)}) - $signed({1'b0, root});
  assign rem_sh = {rem[RAD_W-1:0], num[step]};
  assign ge     = rem_sh >= {1'b0, rq.rad};
  assign rnd    = prod + 32'sd2048;
  assign delta  = DELTA_W'(rnd >>> 12);
  assign done   = phase == P_OUT;

  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= P_IDLE;
    end else begin
      unique case (phase)
        P_IDLE: begin
          if (go) begin
            rq    <= req;
            phase <= P_DX;
          end
        end
        P_DX: begin
          d2_acc <= mul[D2_W-1:0];
          phase  <= P_DZ;
        end
        P_DZ: begin
          target <= {d2_acc + mul[D2_W-1:0], (2 * FRAC)'(0)};
          root   <= '0;
          step   <= 5'(ROOT_W - 1);
          phase  <= P_SQRT;
        end
        P_SQRT: begin
          if (sq_le) root <= trial;
          if (step == 5'd0) begin
            phase <= P_DIV;
            step  <= 5'(NUM_W - 1);
            rem   <= '0;
            quo   <= '0;
          end else begin
            step <= step - 5'd1;
          end
        end
        P_DIV: begin
          if (step == 5'(NUM_W - 1) && n_val <= 0) begin
            phase <= P_MUL;
          end else begin
            if (step == 5'(NUM_W - 1)) begin
              num <= NUM_W'(n_val);
              step <= step - 5'd1;
              rem  <= {6'd0, n_val[NUM_W-1]} >= {1'b0, rq.rad} ?
                      {6'd0, n_val[NUM_W-1]} - {1'b0, rq.rad} : {6'd0, n_val[NUM_W-1]};
              quo  <= {15'd0, {6'd0, n_val[NUM_W-1]} >= {1'b0, rq.rad}};
            end else begin
              rem <= ge ? rem_sh - {1'b0, rq.rad} : rem_sh;
              quo <= {quo[CH_W-2:0], ge};
              if (step == 5'd0) phase <= P_MUL;
              else step <= step - 5'd1;
            end
          end
        end
        P_MUL: begin
          prod  <= 32'(mul);
          phase <= P_OUT;
        end
        default: begin
          phase <= P_IDLE;
        end
      endcase
    end
  end

  ap_go_idle: assert property (@(posedge clk) disable iff (rst)
    go |-> phase == P_IDLE)
    else $error("calc started while running");
  ap_done_pulse: assert property (@(posedge clk) disable iff (rst)
    done |=> !done)
    else $error("calc done longer than one cycle");
  ap_div_after_root: assert property (@(posedge clk) disable iff (rst)
    (phase == P_DIV) |-> ($past(phase) == P_SQRT || $past(phase) == P_DIV))
    else $error("divide entered out of order");

endmodule
`default_nettype wire

[sv/radial_brush_texel_painter_unit.sv]
// Top level: radial brush texel painter with APB registers and texel RAM.
//
// Requests enter on start when busy is low; every request gives exactly one
// result, marked by a one-cycle done strobe with out_red..out_alpha and status.
// The receiver cannot stall; results must be taken on the done cycle.
// Work done per request:
//   write texel: one RAM write; read texel: a RAM read, then the outputs are loaded (RAM read is registered).
//   fill: all MAX_WIDTH*MAX_HEIGHT texels, one texel per cycle through the RAM port.
//   stamp: a walk over the (2r)^2 offsets of the brush square; each in-grid
//   texel goes through the shared calc unit (two squares, a 22-step root, a
//   21-step divide, one gain product), which skips the divide where the
//   falloff is zero.
//   A stamp with zero gain, zero radius or no channel writes nothing.
// One request is worked at a time; busy stays high until done.
// After rst the RAM is cleared to zero by a sweep over all MAX_WIDTH*MAX_HEIGHT
// texels with busy high; APB writes are taken during the sweep.
// map_width (address 0) and map_height (address 4) saturate to 1..MAX.
`default_nettype none
module radial_brush_texel_painter_unit
  import rbtp_pkg::*;
#(
  parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
  parameter int MAX_HEIGHT = DEF_MAX_HEIGHT,
  parameter int MAX_RADIUS = DEF_MAX_RADIUS
) (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              psel,
  input  wire logic              penable,
  input  wire logic              pwrite,
  input  wire logic [2:0]        paddr,
  input  wire logic [31:0]       pwdata,
  output logic      [31:0]       prdata,
  output logic                   pready,
  input  wire logic              start,
  output logic                   busy,
  input  wire logic [1:0]        opcode,
  input  wire logic [POS_W-1:0]  pos_x,
  input  wire logic [POS_W-1:0]  pos_y,
  input  wire logic [RAD_W-1:0]  brush_radius,
  input  wire logic signed [15:0] brush_gain,
  input  wire logic [1:0]        channel_sel,
  input  wire logic [CH_W-1:0]   in_red,
  input  wire logic [CH_W-1:0]   in_green,
  input  wire logic [CH_W-1:0]   in_blue,
  input  wire logic [CH_W-1:0]   in_alpha,
  output logic                   done,
  output logic [CH_W-1:0]        out_red,
  output logic [CH_W-1:0]        out_green,
  output logic [CH_W-1:0]        out_blue,
  output logic [CH_W-1:0]        out_alpha,
  output logic                   status
);

  localparam int DEPTH  = MAX_WIDTH * MAX_HEIGHT;
  localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam logic [7:0] W_CAP = (MAX_WIDTH > 255) ? 8'd255 : 8'(MAX_WIDTH);
  localparam logic [7:0] H_CAP = (MAX_HEIGHT > 255) ? 8'd255 : 8'(MAX_HEIGHT);
  localparam logic [RAD_W-1:0] R_CAP =
    (MAX_RADIUS > 63) ? RAD_W'(63) : RAD_W'(MAX_RADIUS);

  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_SWEEP = 3'd1;
  localparam logic [2:0] ST_SCAN  = 3'd2;
  localparam logic [2:0] ST_CALC  = 3'd3;
  localparam logic [2:0] ST_WRITE = 3'd4;
  localparam logic [2:0] ST_READ  = 3'd5;
  localparam logic [2:0] ST_RDOUT = 3'd6;
  localparam logic [2:0] ST_STAMP = 3'd7;

  logic [7:0]             map_width;
  logic [7:0]             map_height;
  logic [2:0]             state;
  logic [POS_W-1:0]       px;
  logic [POS_W-1:0]       py;
  logic [RAD_W-1:0]       rad;
  logic signed [15:0]     gain;
  logic [1:0]             ch;
  logic [TEXEL_W-1:0]     val;
  logic [RAD_W:0]         ox;
  logic [RAD_W:0]         oy;
  logic [ADDR_W-1:0]      sweep_addr;
  logic [TEXEL_W-1:0]     sweep_val;
  logic                   sweep_report;
  logic [ADDR_W-1:0]      tex_addr;

  logic                   ram_we;
  logic [ADDR_W-1:0]      ram_waddr;
  logic [TEXEL_W-1:0]     ram_wdata;
  logic                   ram_re;
  logic [ADDR_W-1:0]      ram_raddr;
  logic [TEXEL_W-1:0]     ram_rdata;

  logic                   calc_go;
  calc_req_t              calc_req;
  logic                   calc_done;
  logic signed [DELTA_W-1:0] calc_delta;

  logic signed [OFS_W-1:0] dx;
  logic signed [OFS_W-1:0] dz;
  logic signed [OFS_W:0]  xs;
  logic signed [OFS_W:0]  ys;
  logic                   in_grid;
  logic [ADDR_W-1:0]      scan_idx;
  logic                   pos_inside;
  logic [ADDR_W-1:0]      pos_idx;
  logic                   last_x;
  logic                   last_y;
  logic [RAD_W:0]         span_last;
  logic [CH_W-1:0]        old_ch;
  logic signed [DELTA_W:0] new_sum;
  logic [CH_W-1:0]        new_ch;
  logic [TEXEL_W-1:0]     painted;
  logic                   apb_wr;
  logic [7:0]             wv;
  logic [RAD_W-1:0]       rad_in;
  logic                   stamp_live;

  assign pready = 1'b1;
  assign apb_wr = psel && penable && pwrite && pready;
  assign prdata = paddr[2] ? {24'd0, map_height} : {24'd0, map_width};
  assign wv     = pwdata[7:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      map_width  <= (MAX_WIDTH > 128) ? 8'd128 : W_CAP;
      map_height <= (MAX_HEIGHT > 128) ? 8'd128 : H_CAP;
    end else if (apb_wr && paddr[1:0] == 2'd0) begin
      if (!paddr[2]) map_width <= (wv == 8'd0) ? 8'd1 : ((wv > W_CAP) ? W_CAP : wv);
      else map_height <= (wv == 8'd0) ? 8'd1 : ((wv > H_CAP) ? H_CAP : wv);
    end
  end

  assign busy       = state != ST_IDLE;
  assign rad_in     = (brush_radius > R_CAP) ? R_CAP : brush_radius;
  assign stamp_live = brush_gain != 16'sd0 && channel_sel != CH_NONE && rad_in != '0;

  assign dx = $signed({1'b0, ox}) - $signed({2'b00, rad});
  assign dz = $signed({1'b0, oy}) - $signed({2'b00, rad});
  assign xs = $signed({2'b00, px}) + (OFS_W + 1)'(dx);
  assign ys = $signed({2'b00, py}) + (OFS_W + 1)'(dz);
  assign in_grid = !xs[OFS_W] && !ys[OFS_W] &&
                   xs[7:0] < map_width && ys[7:0] < map_height;
  assign scan_idx   = ADDR_W'(32'(ys[7:0]) * MAX_WIDTH + 32'(xs[7:0]));
  assign pos_inside = {1'b0, px} < map_width && {1'b0, py} < map_height;
  assign pos_idx    = ADDR_W'(32'(py) * MAX_WIDTH + 32'(px));
  assign span_last  = {rad, 1'b0} - (RAD_W + 1)'(1);
  assign last_x     = ox == span_last;
  assign last_y     = oy == span_last;

  assign old_ch  = ram_rdata[ch * CH_W +: CH_W];
  assign new_sum = $signed({{(DELTA_W + 1 - CH_W){1'b0}}, old_ch}) +
                   (DELTA_W + 1)'(calc_delta);
  assign new_ch  = new_sum < 0 ? '0 :
                   (new_sum > $signed((DELTA_W + 1)'(ONE)) ? ONE : CH_W'(new_sum));

  always_comb begin
    painted = ram_rdata;
    painted[ch * CH_W +: CH_W] = new_ch;
  end

  assign calc_req = '{dx: dx, dz: dz, rad: rad, gain: gain};
  assign calc_go  = state == ST_SCAN && in_grid;

  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = tex_addr;
    ram_wdata = painted;
    ram_re    = 1'b0;
    ram_raddr = pos_idx;
    unique case (state)
      ST_SWEEP: begin
        ram_we    = 1'b1;
        ram_waddr = sweep_addr;
        ram_wdata = sweep_val;
      end
      ST_SCAN: begin
        ram_re    = in_grid;
        ram_raddr = scan_idx;
      end
      ST_CALC: begin
        ram_we = calc_done;
      end
      ST_WRITE: begin
        ram_we    = pos_inside;
        ram_waddr = pos_idx;
        ram_wdata = val;
      end
      ST_READ: begin
        ram_re = pos_inside;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_SWEEP;
      sweep_addr   <= '0;
      sweep_val    <= '0;
      sweep_report <= 1'b0;
      done         <= 1'b0;
    end else begin
      done <= 1'b0;
      unique case (state) inside
        ST_IDLE: begin
          if (start) begin
            px   <= pos_x;
            py   <= pos_y;
            rad  <= rad_in;
            gain <= brush_gain;
            ch   <= channel_sel;
            val  <= {sat_one(in_alpha), sat_one(in_blue), sat_one(in_green),
                     sat_one(in_red)};
            ox   <= '0;
            oy   <= '0;
            out_red   <= '0;
            out_green <= '0;
            out_blue  <= '0;
            out_alpha <= '0;
            status    <= 1'b0;
            unique case (opcode)
              OP_STAMP: state <= stamp_live ? ST_SCAN : ST_STAMP;
              OP_WRITE: state <= ST_WRITE;
              OP_FILL: begin
                state        <= ST_SWEEP;
                sweep_addr   <= '0;
                sweep_val    <= {sat_one(in_alpha), sat_one(in_blue),
                                 sat_one(in_green), sat_one(in_red)};
                sweep_report <= 1'b1;
              end
              default: state <= ST_READ;
            endcase
          end
        end
        ST_SWEEP: begin
          sweep_addr <= sweep_addr + ADDR_W'(1);
          if (sweep_addr == ADDR_W'(DEPTH - 1)) begin
            state <= ST_IDLE;
            done  <= sweep_report;
          end
        end
        ST_SCAN, ST_CALC: begin
          if (state == ST_SCAN && in_grid) begin
            tex_addr <= scan_idx;
            state    <= ST_CALC;
          end else if (state == ST_SCAN || calc_done) begin
            state <= ST_SCAN;
            if (last_x) begin
              ox <= '0;
              if (last_y) begin
                state <= ST_IDLE;
                done  <= 1'b1;
              end else begin
                oy <= oy + (RAD_W + 1)'(1);
              end
            end else begin
              ox <= ox + (RAD_W + 1)'(1);
            end
          end
        end
        ST_WRITE: begin
          status <= !pos_inside;
          state  <= ST_IDLE;
          done   <= 1'b1;
        end
        ST_READ: begin
          status <= !pos_inside;
          if (pos_inside) begin
            state <= ST_RDOUT;
          end else begin
            state <= ST_IDLE;
            done  <= 1'b1;
          end
        end
        ST_RDOUT: begin
          out_red   <= ram_rdata[0 +: CH_W];
          out_green <= ram_rdata[CH_W +: CH_W];
          out_blue  <= ram_rdata[2 * CH_W +: CH_W];
          out_alpha <= ram_rdata[3 * CH_W +: CH_W];
          state     <= ST_IDLE;
          done      <= 1'b1;
        end
        default: begin
          state <= ST_IDLE;
          done  <= 1'b1;
        end
      endcase
    end
  end

  rbtp_calc u_calc (
    .clk   (clk),
    .rst   (rst),
    .go    (calc_go),
    .req   (calc_req),
    .done  (calc_done),
    .delta (calc_delta)
  );

  rbtp_ram #(
    .WIDTH (TEXEL_W),
    .DEPTH (DEPTH),
    .AW    (ADDR_W)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  ap_idle_no_write: assert property (@(posedge clk) disable iff (rst)
    state == ST_IDLE |-> !ram_we)
    else $error("RAM written while idle");
  ap_done_pulse: assert property (@(posedge clk) disable iff (rst)
    done |=> !done)
    else $error("done longer than one cycle");
  ap_done_after_busy: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(busy))
    else $error("result without a request in flight");
  ap_calc_in_stamp: assert property (@(posedge clk) disable iff (rst)
    calc_done |-> state == ST_CALC)
    else $error("calc result outside stamp walk");

endmodule
`default_nettype wire
